[rtl/mbsrr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsrr_pkg
// Shared codes, frame layout and the CRC-16 byte update for the read
// holding register responder.
// ----------------------------------------------------------------------------
package mbsrr_pkg;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_WRITE = 2'd1,
    OP_TX    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_ADDR_ERR = 3'd2,
    ST_CRC_ERR  = 3'd3,
    ST_QTY_ERR  = 3'd4,
    ST_BUSY     = 3'd5
  } status_t;

  // byte positions inside a request frame
  localparam logic [2:0] POS_ADDR     = 3'd0;
  localparam logic [2:0] POS_FUNC     = 3'd1;
  localparam logic [2:0] POS_START_HI = 3'd2;
  localparam logic [2:0] POS_START_LO = 3'd3;
  localparam logic [2:0] POS_QTY_HI   = 3'd4;
  localparam logic [2:0] POS_QTY_LO   = 3'd5;
  localparam logic [2:0] POS_CRC_LO   = 3'd6;
  localparam logic [2:0] POS_CRC_HI   = 3'd7;

  localparam logic [3:0]  FRAME_LEN       = 4'd8;
  localparam logic [8:0]  HDR_LEN         = 9'd3;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  SLAVE_ADDR_INIT = 8'h01;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/modbus_slave_read_responder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_slave_read_responder_core
// RTU slave answering read holding register requests from a register table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per request byte
//   (op 0), host table write (op 1) or transmitter-ready tick (op 2).
//   Output channel (out_valid/out_ready) carries one item per status event
//   (request complete, byte dropped while busy) or per response byte.
//   Config channel (cfg_valid/cfg_ready) sets the station address; it is
//   always ready and must only be written while the block is idle.
// Timing:
//   An accepted item is registered into the processing stage, and its result
//   is loaded into the output register when that stage advances.
//   With the receiver ready an item is taken every cycle; the single port
//   register table is read or written once per item at acceptance.
// Reset:
//   Reset clears control state and starts a table clearing pass that
//   writes zero to every entry, during which in_ready stays low.
// Stall:
//   When out_ready is low the output register holds, the item behind it
//   waits in the processing stage and in_ready drops.
// ----------------------------------------------------------------------------
module modbus_slave_read_responder_core #(
  parameter int REG_DEPTH    = 64,
  parameter int MAX_QUANTITY = 127
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  input  logic [5:0]  reg_index,
  input  logic [15:0] reg_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int            AW       = $clog2(REG_DEPTH);
  localparam logic [AW:0]   DEPTH    = (AW + 1)'(REG_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(REG_DEPTH - 1);
  localparam logic [15:0]   MAX_QTY  = 16'(MAX_QUANTITY);

  // shift one byte into a remainder modulo the table depth, MSB first
  function automatic logic [AW-1:0] mod_shift8(input logic [AW-1:0] r_in, input logic [7:0] b);
    logic [AW:0] r;
    r = {1'b0, r_in};
    for (int i = 7; i >= 0; i--) begin
      r = {r[AW-1:0], b[i]};
      if (r >= DEPTH) begin
        r = r - DEPTH;
      end
    end
    return r[AW-1:0];
  endfunction

  // table and clearing pass
  logic [15:0]   mem [REG_DEPTH];
  logic [15:0]   rd_data;
  logic          clr_active;
  logic [AW-1:0] clr_addr;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] wr_idx;

  // processing stage
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [7:0] s1_rx;
  logic       s1_fs;
  logic       s1_adv;
  logic       accept;

  logic [7:0] slave_address;

  // request bytes, no reset
  logic [7:0]    req_addr,  req_addr_next;
  logic [7:0]    req_func,  req_func_next;
  logic [7:0]    qty_hi,    qty_hi_next;
  logic [7:0]    qty_lo,    qty_lo_next;
  logic [AW-1:0] start_idx, start_idx_next;
  logic [7:0]    nbytes,    nbytes_next;

  logic [3:0]    rx_count,  rx_count_next;
  logic [15:0]   rx_crc,    rx_crc_next;
  logic          pending,   pending_next;
  logic [8:0]    send_pos,  send_pos_next;
  logic [15:0]   send_crc,  send_crc_next;
  logic [AW-1:0] ptr,       ptr_next;

  logic          out_valid_next;
  logic          res_load;
  logic          res_tx_valid;
  logic [7:0]    res_byte;
  logic          res_last;
  logic [2:0]    res_status;

  logic [3:0]    rx_cnt_eff;
  logic [15:0]   rx_crc_eff;
  logic [15:0]   rx_crc_upd;
  logic [AW-1:0] start_step;
  logic [8:0]    data_end;
  logic [7:0]    tx_sel;
  logic          tx_sel_last;
  logic          in_data;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !clr_active && (!s1_valid || s1_adv);
  assign accept    = in_valid && in_ready;

  assign wr_idx    = mod_shift8('0, {2'b00, reg_index});
  assign mem_we    = clr_active || (accept && op == mbsrr_pkg::OP_WRITE);
  assign mem_re    = accept && op != mbsrr_pkg::OP_WRITE;
  assign mem_waddr = clr_active ? clr_addr : wr_idx;
  assign mem_wdata = clr_active ? 16'h0000 : reg_value;

  // single port table; reads follow the pointer as it will stand after
  // the item now in the processing stage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end else if (mem_re) begin
      rd_data <= mem[ptr_next];
    end
  end

  assign rx_cnt_eff = s1_fs ? 4'd0 : rx_count;
  assign rx_crc_eff = s1_fs ? mbsrr_pkg::CRC_INIT : rx_crc;
  assign rx_crc_upd = mbsrr_pkg::crc16_byte(rx_crc_eff, s1_rx);
  assign start_step = mod_shift8((rx_cnt_eff[2:0] == mbsrr_pkg::POS_START_HI) ? '0 : start_idx,
                                 s1_rx);
  assign data_end   = mbsrr_pkg::HDR_LEN + {1'b0, nbytes};
  assign in_data    = send_pos >= mbsrr_pkg::HDR_LEN && send_pos < data_end;

  // response byte at the current send position
  always_comb begin
    tx_sel_last = 1'b0;
    priority if (send_pos == 9'd0) begin
      tx_sel = req_addr;
    end else if (send_pos == 9'd1) begin
      tx_sel = req_func;
    end else if (send_pos == 9'd2) begin
      tx_sel = nbytes;
    end else if (send_pos < data_end) begin
      // odd positions carry the high byte of a register
      tx_sel = send_pos[0] ? rd_data[15:8] : rd_data[7:0];
    end else if (send_pos == data_end) begin
      tx_sel = send_crc[7:0];
    end else begin
      tx_sel      = send_crc[15:8];
      tx_sel_last = 1'b1;
    end
  end

  always_comb begin
    req_addr_next  = req_addr;
    req_func_next  = req_func;
    qty_hi_next    = qty_hi;
    qty_lo_next    = qty_lo;
    start_idx_next = start_idx;
    nbytes_next    = nbytes;
    rx_count_next  = rx_count;
    rx_crc_next    = rx_crc;
    pending_next   = pending;
    send_pos_next  = send_pos;
    send_crc_next  = send_crc;
    ptr_next       = ptr;
    res_load       = 1'b0;
    res_tx_valid   = 1'b0;
    res_byte       = 8'h00;
    res_last       = 1'b0;
    res_status     = mbsrr_pkg::ST_NONE;

    if (s1_adv) begin
      case (s1_op)
        mbsrr_pkg::OP_RX: begin
          if (pending) begin
            res_load   = 1'b1;
            res_status = mbsrr_pkg::ST_BUSY;
          end else begin
            rx_count_next = rx_cnt_eff;
            rx_crc_next   = rx_crc_eff;
            if (rx_cnt_eff < mbsrr_pkg::FRAME_LEN) begin
              rx_crc_next   = rx_crc_upd;
              rx_count_next = rx_cnt_eff + 4'd1;
              unique case (rx_cnt_eff[2:0])
                mbsrr_pkg::POS_ADDR:     req_addr_next  = s1_rx;
                mbsrr_pkg::POS_FUNC:     req_func_next  = s1_rx;
                mbsrr_pkg::POS_START_HI: start_idx_next = start_step;
                mbsrr_pkg::POS_START_LO: start_idx_next = start_step;
                mbsrr_pkg::POS_QTY_HI:   qty_hi_next    = s1_rx;
                mbsrr_pkg::POS_QTY_LO:   qty_lo_next    = s1_rx;
                mbsrr_pkg::POS_CRC_LO: ;
                mbsrr_pkg::POS_CRC_HI: begin
                  res_load = 1'b1;
                  priority if (req_addr != slave_address) begin
                    res_status = mbsrr_pkg::ST_ADDR_ERR;
                  end else if (rx_crc_upd != 16'h0000) begin
                    res_status = mbsrr_pkg::ST_CRC_ERR;
                  end else if ({qty_hi, qty_lo} > MAX_QTY) begin
                    res_status = mbsrr_pkg::ST_QTY_ERR;
                  end else begin
                    res_status    = mbsrr_pkg::ST_ACCEPTED;
                    pending_next  = 1'b1;
                    send_pos_next = 9'd0;
                    send_crc_next = mbsrr_pkg::CRC_INIT;
                    ptr_next      = start_idx;
                    nbytes_next   = {qty_lo[6:0], 1'b0};
                  end
                end
              endcase
            end
          end
        end
        mbsrr_pkg::OP_TX: begin
          if (pending) begin
            res_load     = 1'b1;
            res_tx_valid = 1'b1;
            res_byte     = tx_sel;
            res_last     = tx_sel_last;
            if (send_pos < data_end) begin
              send_crc_next = mbsrr_pkg::crc16_byte(send_crc, tx_sel);
            end
            // step to the next register after its low byte
            if (in_data && !send_pos[0]) begin
              ptr_next = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
            end
            if (tx_sel_last) begin
              pending_next  = 1'b0;
              send_pos_next = 9'd0;
            end else begin
              send_pos_next = send_pos + 9'd1;
            end
          end
        end
        default: ;  // table writes happen at acceptance
      endcase
    end

    out_valid_next = s1_adv ? res_load : (out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active    <= 1'b1;
      clr_addr      <= '0;
      s1_valid      <= 1'b0;
      slave_address <= mbsrr_pkg::SLAVE_ADDR_INIT;
      rx_count      <= 4'd0;
      rx_crc        <= mbsrr_pkg::CRC_INIT;
      pending       <= 1'b0;
      send_pos      <= 9'd0;
      send_crc      <= mbsrr_pkg::CRC_INIT;
      ptr           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_IDX) begin
          clr_active <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (cfg_valid) begin
        slave_address <= cfg_data;
      end
      rx_count  <= rx_count_next;
      rx_crc    <= rx_crc_next;
      pending   <= pending_next;
      send_pos  <= send_pos_next;
      send_crc  <= send_crc_next;
      ptr       <= ptr_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= op;
      s1_rx <= rx_byte;
      s1_fs <= frame_start;
    end
    req_addr  <= req_addr_next;
    req_func  <= req_func_next;
    qty_hi    <= qty_hi_next;
    qty_lo    <= qty_lo_next;
    start_idx <= start_idx_next;
    nbytes    <= nbytes_next;
    if (s1_adv) begin
      tx_valid <= res_tx_valid;
      tx_byte  <= res_byte;
      tx_last  <= res_last;
      status   <= res_status;
    end
  end

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !in_ready)
    else $error("item accepted during table clear");

  a_last_is_tx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx_last) |-> (tx_valid && status == mbsrr_pkg::ST_NONE))
    else $error("last flag on a status item");

  a_tx_no_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx_valid) |-> status == mbsrr_pkg::ST_NONE)
    else $error("response byte carries a status code");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= LAST_IDX)
    else $error("table pointer out of range");

  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(pending) |-> (out_valid && tx_valid && tx_last))
    else $error("response ended without its last byte");

endmodule
